>>> design/itp_pkg.sv
// Shared constants for the interval table lookup block.
`timescale 1ns / 1ps

package itp_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned ValW       = 32;
  localparam int unsigned EntryW     = 3 * ValW;

  localparam logic [1:0] ActInsert = 2'd0;
  localparam logic [1:0] ActPoint  = 2'd1;
  localparam logic [1:0] ActRange  = 2'd2;

  localparam logic [1:0] StOk         = 2'd0;
  localparam logic [1:0] StInvalid    = 2'd1;
  localparam logic [1:0] StNotCovered = 2'd2;
  localparam logic [1:0] StFull       = 2'd3;

endpackage

>>> design/itp_if.sv
// Request and response channel interfaces of the interval table lookup block.
`timescale 1ns / 1ps

interface itp_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] point_or_start;
  logic signed [31:0] range_end;
  logic signed [31:0] entry_id;

  modport source (output valid, action, point_or_start, range_end, entry_id, input ready);
  modport sink   (input valid, action, point_or_start, range_end, entry_id, output ready);
endinterface

interface itp_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] found_id;

  modport source (output valid, status, found_id, input ready);
  modport sink   (input valid, status, found_id, output ready);
endinterface

>>> design/interval_table_lookup.sv
// Top level of the interval table lookup block: slot memory, scan sequencer, result register.
`timescale 1ns / 1ps

// Holds up to TableDepth intervals (start, inclusive end, ID), keyed by start.
// A request is taken only when the block is idle. The block then accepts it,
// sweeps the slot memory slot by slot through its single synchronous read
// port, drains the last read, and settles the result and, for an insert,
// writes the slot back once the output register is free.
// The response sits in an output register, so a new request is accepted while
// an earlier response still waits. Insert overwrites the slot with the same
// start, else takes the lowest free slot, else reports table full. Point and
// range lookups use the valid slot with the greatest start not above the key;
// ties go to the lowest slot. Status: ok, invalid (start >= end, or unused
// action), not covered, table full. found_id is zero unless a lookup hits.
// No clearing pass: slot valid bits are flip-flops cleared by reset.
module interval_table_lookup
  import itp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  itp_req_if.sink    in_i,
  itp_rsp_if.source  out_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // request held for the length of the sweep
  logic [1:0]         act_q;
  logic signed [31:0] key_q;
  logic signed [31:0] rend_q;
  logic signed [31:0] id_q;
  logic               bad_q;

  // sweep address and the read in flight
  logic [IdxW-1:0]    cnt_q;
  logic               rd_pend_q;
  logic [IdxW-1:0]    rd_idx_q;
  logic               rd_valid_q;
  logic [EntryW-1:0]  rd_data_q;

  // slot memory and its valid bits
  logic [EntryW-1:0]  mem_q [TableDepth];
  logic               slot_valid_q [TableDepth];

  // sweep results
  logic               match_hit_q;
  logic [IdxW-1:0]    match_idx_q;
  logic               free_hit_q;
  logic [IdxW-1:0]    free_idx_q;
  logic               pred_hit_q;
  logic signed [31:0] pred_start_q;
  logic signed [31:0] pred_end_q;
  logic signed [31:0] pred_id_q;

  // response register
  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic signed [31:0] out_id_q;

  logic signed [31:0] ent_start, ent_end, ent_id;
  logic               accept, out_free, finish;
  logic               wr_en;
  logic [IdxW-1:0]    wr_idx;
  logic [1:0]         fin_status;
  logic signed [31:0] fin_id;

  assign ent_start = $signed(rd_data_q[EntryW-1 -: ValW]);
  assign ent_end   = $signed(rd_data_q[2*ValW-1 -: ValW]);
  assign ent_id    = $signed(rd_data_q[ValW-1:0]);

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign finish     = (state_q == S_FIN) && out_free;

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_status_q;
  assign out_o.found_id = out_id_q;

  // outcome of the request once the sweep is done
  always_comb begin
    fin_status = StOk;
    fin_id     = '0;
    wr_en      = 1'b0;
    wr_idx     = match_hit_q ? match_idx_q : free_idx_q;
    case (act_q)
      ActInsert: begin
        if (bad_q) begin
          fin_status = StInvalid;
        end else if (!match_hit_q && !free_hit_q) begin
          fin_status = StFull;
        end else begin
          wr_en = finish;
        end
      end
      ActPoint: begin
        if (pred_hit_q && pred_end_q >= key_q) begin
          fin_id = pred_id_q;
        end else begin
          fin_status = StNotCovered;
        end
      end
      ActRange: begin
        if (bad_q) begin
          fin_status = StInvalid;
        end else if (pred_hit_q && pred_end_q >= rend_q) begin
          fin_id = pred_id_q;
        end else begin
          fin_status = StNotCovered;
        end
      end
      default: fin_status = StInvalid;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_SCAN;
      S_SCAN:  if (cnt_q == IdxW'(TableDepth - 1)) state_d = S_DRAIN;
      S_DRAIN: state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      match_hit_q <= 1'b0;
      free_hit_q  <= 1'b0;
      pred_hit_q  <= 1'b0;
      for (int i = 0; i < TableDepth; i++) slot_valid_q[i] <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= (state_q == S_SCAN);
      if (accept) begin
        cnt_q       <= '0;
        match_hit_q <= 1'b0;
        free_hit_q  <= 1'b0;
        pred_hit_q  <= 1'b0;
      end else begin
        if (state_q == S_SCAN && cnt_q != IdxW'(TableDepth - 1)) cnt_q <= cnt_q + 1'b1;
        if (rd_pend_q) begin
          if (rd_valid_q) begin
            if (!match_hit_q && ent_start == key_q) match_hit_q <= 1'b1;
            if (ent_start <= key_q) pred_hit_q <= 1'b1;
          end else begin
            free_hit_q <= 1'b1;
          end
        end
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (wr_en) slot_valid_q[wr_idx] <= 1'b1;
    end
  end

  // sweep payload: first matching start, first free slot, best predecessor
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= in_i.action;
      key_q  <= in_i.point_or_start;
      rend_q <= in_i.range_end;
      id_q   <= in_i.entry_id;
      bad_q  <= in_i.point_or_start >= in_i.range_end;
    end
    if (rd_pend_q) begin
      if (rd_valid_q) begin
        if (!match_hit_q && ent_start == key_q) match_idx_q <= rd_idx_q;
        if (ent_start <= key_q && (!pred_hit_q || ent_start > pred_start_q)) begin
          pred_start_q <= ent_start;
          pred_end_q   <= ent_end;
          pred_id_q    <= ent_id;
        end
      end else if (!free_hit_q) begin
        free_idx_q <= rd_idx_q;
      end
    end
    if (finish) begin
      out_status_q <= fin_status;
      out_id_q     <= fin_id;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_idx] <= {key_q, rend_q, id_q};
    rd_data_q  <= mem_q[cnt_q];
    rd_valid_q <= slot_valid_q[cnt_q];
    rd_idx_q   <= cnt_q;
  end

endmodule
